// ----- design/ptsp_pkg.sv -----
package ptsp_pkg;

    localparam int TABLE_LEN   = 24;
    localparam int GUARD_SHIFT = 10;
    localparam int XW          = 29;
    localparam int ZW          = 34;
    localparam int AW          = 17;
    localparam int DW          = 17;
    localparam int P1W         = 34;
    localparam int KW          = 24;
    localparam int P2W         = 58;
    localparam int VW          = 60;
    localparam int FRAC_SHIFT  = 37;

    localparam logic signed [ZW-1:0] PI_Q30     = 34'sd3373259426;
    localparam logic signed [KW-1:0] INV314_Q24 = 24'sd5343062;
    localparam logic [15:0]          HOME_H     = 16'd1500;
    localparam logic [15:0]          HOME_V     = 16'd2300;

    localparam logic [15:0] RESET_MAX    = 16'd2300;
    localparam logic [15:0] RESET_MIN    = 16'd700;
    localparam logic [15:0] RESET_HEIGHT = 16'd150;

    localparam logic [1:0] REG_MAX_PULSE = 2'd0;
    localparam logic [1:0] REG_MIN_PULSE = 2'd1;
    localparam logic [1:0] REG_HEIGHT    = 2'd2;

    typedef struct packed {
        logic valid;
        logic home;
    } ptsp_ctl_t;

    function automatic logic [30:0] atan_q30(input int idx);
        logic [30:0] r;
        case (idx)
            0:  r = 31'h3243F6A8;
            1:  r = 31'h1DAC6705;
            2:  r = 31'h0FADBAFC;
            3:  r = 31'h07F56EA6;
            4:  r = 31'h03FEAB76;
            5:  r = 31'h01FFD55B;
            6:  r = 31'h00FFFAAA;
            7:  r = 31'h007FFF55;
            8:  r = 31'h003FFFEA;
            9:  r = 31'h001FFFFD;
            10: r = 31'h000FFFFF;
            11: r = 31'h0007FFFF;
            12: r = 31'h0003FFFF;
            13: r = 31'h0001FFFF;
            14: r = 31'h0000FFFF;
            15: r = 31'h00007FFF;
            16: r = 31'h00003FFF;
            17: r = 31'h00001FFF;
            18: r = 31'h00000FFF;
            19: r = 31'h000007FF;
            20: r = 31'h000003FF;
            21: r = 31'h000001FF;
            22: r = 31'h000000FF;
            23: r = 31'h0000007F;
            default: r = 31'h0;
        endcase
        return r;
    endfunction

endpackage

// ----- design/ptsp_cordic.sv -----
module ptsp_cordic #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  ptsp_pkg::ptsp_ctl_t          in_ctl,
    input  logic signed [15:0]           x_in,
    input  logic signed [15:0]           y_in,
    output ptsp_pkg::ptsp_ctl_t          out_ctl,
    output logic signed [ptsp_pkg::AW-1:0] angle
);
    import ptsp_pkg::*;

    localparam int NS = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

    logic signed [XW-1:0] x_reg [0:NS];
    logic signed [XW-1:0] y_reg [0:NS];
    logic signed [ZW-1:0] z_reg [0:NS];
    logic                 zero_reg [0:NS];
    ptsp_ctl_t            ctl_reg [0:NS];

    logic signed [XW-1:0] xs_next;
    logic signed [XW-1:0] ys_next;

    ptsp_ctl_t            out_ctl_reg;
    logic signed [AW-1:0] angle_reg;
    logic signed [ZW-1:0] z_round;

    assign xs_next = XW'(x_in) <<< GUARD_SHIFT;
    assign ys_next = XW'(y_in) <<< GUARD_SHIFT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg[0] <= '0;
        end else if (en) begin
            ctl_reg[0] <= in_ctl;
        end
        if (en) begin
            zero_reg[0] <= (x_in == 16'sd0) && (y_in == 16'sd0);
            if (x_in < 16'sd0) begin
                z_reg[0] <= (y_in >= 16'sd0) ? PI_Q30 : -PI_Q30;
                x_reg[0] <= -xs_next;
                y_reg[0] <= -ys_next;
            end else begin
                z_reg[0] <= '0;
                x_reg[0] <= xs_next;
                y_reg[0] <= ys_next;
            end
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_stage
        localparam logic signed [ZW-1:0] ATAN_I = ZW'(atan_q30(i));
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_reg[i+1] <= '0;
            end else if (en) begin
                ctl_reg[i+1] <= ctl_reg[i];
            end
            if (en) begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_I;
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_I;
                end
            end
        end
    end

    assign z_round = (z_reg[NS] + ZW'(65536)) >>> 17;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_ctl_reg <= '0;
        end else if (en) begin
            out_ctl_reg <= ctl_reg[NS];
        end
        if (en) begin
            angle_reg <= zero_reg[NS] ? '0 : z_round[AW-1:0];
        end
    end

    assign out_ctl = out_ctl_reg;
    assign angle   = angle_reg;

endmodule

// ----- design/ptsp_pulse.sv -----
module ptsp_pulse (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  ptsp_pkg::ptsp_ctl_t            in_ctl,
    input  logic signed [ptsp_pkg::AW-1:0] angle,
    input  logic [15:0]                    max_pulse,
    input  logic [15:0]                    min_pulse,
    input  logic [15:0]                    home_pulse,
    output ptsp_pkg::ptsp_ctl_t            out_ctl,
    output logic [15:0]                    pulse
);
    import ptsp_pkg::*;

    ptsp_ctl_t             a_ctl_reg, b_ctl_reg, c_ctl_reg;
    logic signed [P1W-1:0] p1_reg;
    logic signed [P2W-1:0] p2_reg;
    logic [15:0]           pulse_reg;

    logic signed [DW-1:0]  diff;
    logic signed [VW-1:0]  v_next;
    logic [VW-FRAC_SHIFT-1:0] q_next;
    logic [15:0]           pulse_next;

    assign diff   = $signed({1'b0, max_pulse}) - $signed({1'b0, min_pulse});
    assign v_next = ($signed({{(VW-16){1'b0}}, max_pulse}) <<< FRAC_SHIFT)
                    - VW'(p2_reg);
    assign q_next = v_next[VW-1:FRAC_SHIFT];

    always_comb begin
        if (b_ctl_reg.home) begin
            pulse_next = home_pulse;
        end else if (v_next < 0) begin
            pulse_next = '0;
        end else if (q_next > (VW-FRAC_SHIFT)'(65535)) begin
            pulse_next = 16'hFFFF;
        end else begin
            pulse_next = q_next[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_ctl_reg <= '0;
            b_ctl_reg <= '0;
            c_ctl_reg <= '0;
        end else if (en) begin
            a_ctl_reg <= in_ctl;
            b_ctl_reg <= a_ctl_reg;
            c_ctl_reg <= b_ctl_reg;
        end
        if (en) begin
            p1_reg    <= P1W'(diff) * P1W'(angle);
            p2_reg    <= P2W'(p1_reg) * P2W'(INV314_Q24);
            pulse_reg <= pulse_next;
        end
    end

    assign out_ctl = c_ctl_reg;
    assign pulse   = pulse_reg;

endmodule

// ----- design/pan_tilt_servo_pulse_from_xy_top.sv -----
// Channel   Direction  Fields (lowest bit up)
// s_axis    in         tdata: target_x[15:0], target_y[31:16]
// m_axis    out        tdata: horizontal_pulse[15:0], vertical_pulse[31:16]
// cfg       in         cfg_addr: 0 max pulse, 1 min pulse, 2 target height
//
// One point is taken per cycle while the output is not stalled; the CORDIC
// pipeline has CORDIC_STAGES stages, at most 24 CORDIC stages.
// Reset clears the valid bits and loads the register defaults.
// A stall at the output freezes the whole pipeline, so nothing is lost.
module pan_tilt_servo_pulse_from_xy_top #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // target_x, target_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // horizontal_pulse, vertical_pulse
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import ptsp_pkg::*;

    logic [15:0] max_pulse_reg;
    logic [15:0] min_pulse_reg;
    logic [15:0] height_reg;

    logic        advance;
    ptsp_ctl_t   in_ctl;
    ptsp_ctl_t   hc_ctl, vc_ctl, hp_ctl, vp_ctl;
    logic signed [AW-1:0] h_angle, v_angle;
    logic [15:0] h_pulse, v_pulse;

    logic signed [15:0] tx, ty;

    assign tx = $signed(s_tdata[15:0]);
    assign ty = $signed(s_tdata[31:16]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_pulse_reg <= RESET_MAX;
            min_pulse_reg <= RESET_MIN;
            height_reg    <= RESET_HEIGHT;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_MAX_PULSE: max_pulse_reg <= cfg_wdata;
                REG_MIN_PULSE: min_pulse_reg <= cfg_wdata;
                REG_HEIGHT:    height_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    assign in_ctl.valid = s_tvalid;
    assign in_ctl.home  = (tx == 16'sd0) && (ty == 16'sd0);

    ptsp_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_h (
        .aclk(aclk), .aresetn(aresetn), .en(advance), .in_ctl(in_ctl),
        .x_in(tx), .y_in(ty), .out_ctl(hc_ctl), .angle(h_angle)
    );

    ptsp_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_v (
        .aclk(aclk), .aresetn(aresetn), .en(advance), .in_ctl(in_ctl),
        .x_in($signed(height_reg)), .y_in(ty), .out_ctl(vc_ctl), .angle(v_angle)
    );

    ptsp_pulse u_pulse_h (
        .aclk(aclk), .aresetn(aresetn), .en(advance), .in_ctl(hc_ctl),
        .angle(h_angle), .max_pulse(max_pulse_reg), .min_pulse(min_pulse_reg),
        .home_pulse(HOME_H), .out_ctl(hp_ctl), .pulse(h_pulse)
    );

    ptsp_pulse u_pulse_v (
        .aclk(aclk), .aresetn(aresetn), .en(advance), .in_ctl(vc_ctl),
        .angle(v_angle), .max_pulse(max_pulse_reg), .min_pulse(min_pulse_reg),
        .home_pulse(HOME_V), .out_ctl(vp_ctl), .pulse(v_pulse)
    );

    assign m_tvalid = hp_ctl.valid && vp_ctl.valid;
    assign m_tdata  = {v_pulse, h_pulse};

endmodule
